[hw/rtl/cbpe_pkg.sv]
`timescale 1ns / 1ps

package cbpe_pkg;

    localparam int COORD_BITS  = 10;
    localparam int MAX_POINTS  = 64;
    localparam int WINDOW      = 64;
    localparam int MARGIN_SPAN = 3;

    localparam int PT_W   = 2 * COORD_BITS;
    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ROW_W  = $clog2(WINDOW);
    localparam int EXT_W  = COORD_BITS + 2;
    localparam int PIDX_W = 6;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXTENT   = 2'd2;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last;
    } t_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] border_x;
        logic [COORD_BITS-1:0] border_y;
        logic [PIDX_W-1:0]     point_index;
        logic                  end_of_run;
        logic [STAT_W-1:0]     status;
    } t_out;

endpackage

[hw/rtl/cbpe_ram.sv]
`timescale 1ns / 1ps

module cbpe_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/cluster_border_pixel_extract.sv]
// Operation: a cluster of N points loads one point per cycle; S_CHECK then
// either reports an overflow or extent error, or builds the occupancy bitmap
// (S_BROW, S_BWR per point) and scans neighbours (S_R0 to S_R3 per point, one
// bitmap row read per cycle unless S_R3 stalls on output). The next cluster
// waits for this one and any row clearing sweep; the bitmap has one read port.
// Reset: synchronous, active low; a clearing sweep of all WINDOW rows follows.
`timescale 1ns / 1ps

module cluster_border_pixel_extract
    import cbpe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic [3:0] {
        S_CLEAR, S_LOAD, S_CHECK, S_ERR, S_BROW, S_BWR,
        S_R0, S_R1, S_R2, S_R3, S_FLUSH
    } t_state;

    t_state                r_state;
    logic [ROW_W-1:0]      r_clr;
    logic [CNT_W-1:0]      r_cnt;
    logic [COORD_BITS-1:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic                  r_ovf;
    logic [STAT_W-1:0]     r_err;
    logic [IDX_W-1:0]      r_k;
    logic [IDX_W-1:0]      n_k;
    logic [ROW_W-1:0]      r_cx, r_cy;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [2:0]            r_up, r_mid;
    logic                  r_out_valid;
    t_out                  r_out;
    logic                  r_pend_valid;
    t_out                  r_pend;

    logic                  in_acc, out_free, k_last, border, stall, advance;
    logic                  out_load;
    logic [PT_W-1:0]       st_rdata;
    logic [COORD_BITS-1:0] sx, sy, dx, dy;
    logic [ROW_W-1:0]      s_cx, s_cy, s_cy_m1;
    logic [WINDOW-1:0]     bm_rdata, bm_wdata;
    logic [ROW_W-1:0]      bm_raddr, bm_waddr;
    logic                  bm_we;
    logic [2:0]            nb_dn;
    logic                  extent_bad;

    function automatic logic [2:0] nb3(input logic [WINDOW-1:0] row,
                                       input logic [ROW_W-1:0] c);
        logic [WINDOW-1:0] s;
        s = row >> (c - ROW_W'(1));
        return s[2:0];
    endfunction

    cbpe_ram #(.DEPTH(MAX_POINTS), .WIDTH(PT_W), .AW(IDX_W)) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && (r_cnt < CNT_W'(MAX_POINTS))),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata ({i_in_data.y, i_in_data.x}),
        .i_raddr (n_k),
        .o_rdata (st_rdata)
    );

    cbpe_ram #(.DEPTH(WINDOW), .WIDTH(WINDOW), .AW(ROW_W)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    assign o_in_ready  = (r_state == S_LOAD);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    assign sx      = st_rdata[COORD_BITS-1:0];
    assign sy      = st_rdata[PT_W-1:COORD_BITS];
    assign dx      = sx - r_min_x + COORD_BITS'(1);
    assign dy      = sy - r_min_y;
    assign s_cx    = dx[ROW_W-1:0];
    assign s_cy_m1 = dy[ROW_W-1:0];
    assign s_cy    = s_cy_m1 + ROW_W'(1);

    assign k_last  = ((CNT_W'(r_k) + CNT_W'(1)) == r_cnt);
    assign nb_dn   = nb3(bm_rdata, r_cx);
    assign border  = !((&r_up) && r_mid[0] && r_mid[2] && (&nb_dn));
    assign stall   = border && r_pend_valid && !out_free;
    assign advance = (r_state == S_BWR) || ((r_state == S_R3) && !stall);

    assign out_load = ((r_state == S_ERR) && out_free) ||
                      ((r_state == S_R3) && !stall && border && r_pend_valid) ||
                      ((r_state == S_FLUSH) && out_free && r_pend_valid);

    assign extent_bad =
        (EXT_W'(r_max_x - r_min_x) + EXT_W'(MARGIN_SPAN) > EXT_W'(WINDOW)) ||
        (EXT_W'(r_max_y - r_min_y) + EXT_W'(MARGIN_SPAN) > EXT_W'(WINDOW));

    always_comb begin
        if (r_state == S_CHECK) begin
            n_k = '0;
        end else if (advance) begin
            n_k = k_last ? '0 : r_k + IDX_W'(1);
        end else begin
            n_k = r_k;
        end
    end

    always_comb begin
        case (r_state)
            S_BROW:       bm_raddr = s_cy;
            S_R0:         bm_raddr = s_cy_m1;
            S_R2, S_R3:   bm_raddr = r_cy + ROW_W'(1);
            default:      bm_raddr = r_cy;
        endcase
        bm_we    = (r_state == S_BWR) || (r_state == S_CLEAR);
        bm_waddr = (r_state == S_CLEAR) ? r_clr : r_cy;
        bm_wdata = (r_state == S_CLEAR) ? '0
                 : (bm_rdata | ({{(WINDOW-1){1'b0}}, 1'b1} << r_cx));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_cnt        <= '0;
            r_min_x      <= '1;
            r_min_y      <= '1;
            r_max_x      <= '0;
            r_max_y      <= '0;
            r_ovf        <= 1'b0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_k <= n_k;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr == ROW_W'(WINDOW - 1)) begin
                        r_clr   <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_clr   <= r_clr + ROW_W'(1);
                    end
                end
                S_LOAD: begin
                    if (in_acc) begin
                        if (r_cnt < CNT_W'(MAX_POINTS)) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                            if (i_in_data.x < r_min_x) r_min_x <= i_in_data.x;
                            if (i_in_data.x > r_max_x) r_max_x <= i_in_data.x;
                            if (i_in_data.y < r_min_y) r_min_y <= i_in_data.y;
                            if (i_in_data.y > r_max_y) r_max_y <= i_in_data.y;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_data.last) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_ovf) begin
                        r_err   <= ST_OVERFLOW;
                        r_state <= S_ERR;
                    end else if (extent_bad) begin
                        r_err   <= ST_EXTENT;
                        r_state <= S_ERR;
                    end else begin
                        r_state <= S_BROW;
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_out       <= '{border_x: '0, border_y: '0, point_index: '0,
                                         end_of_run: 1'b1, status: r_err};
                        r_cnt       <= '0;
                        r_min_x     <= '1;
                        r_min_y     <= '1;
                        r_max_x     <= '0;
                        r_max_y     <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_LOAD;
                    end
                end
                S_BROW: begin
                    r_cx    <= s_cx;
                    r_cy    <= s_cy;
                    r_state <= S_BWR;
                end
                S_BWR: begin
                    r_state <= k_last ? S_R0 : S_BROW;
                end
                S_R0: begin
                    r_px    <= sx;
                    r_py    <= sy;
                    r_cx    <= s_cx;
                    r_cy    <= s_cy;
                    r_state <= S_R1;
                end
                S_R1: begin
                    r_up    <= nb3(bm_rdata, r_cx);
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_mid   <= nb3(bm_rdata, r_cx);
                    r_state <= S_R3;
                end
                S_R3: begin
                    if (!stall) begin
                        if (border) begin
                            if (r_pend_valid) begin
                                r_out <= r_pend;
                            end
                            r_pend       <= '{border_x: r_px, border_y: r_py,
                                              point_index: PIDX_W'(r_k),
                                              end_of_run: 1'b0, status: ST_OK};
                            r_pend_valid <= 1'b1;
                        end
                        r_state <= k_last ? S_FLUSH : S_R0;
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        if (r_pend_valid) begin
                            r_out <= '{border_x: r_pend.border_x,
                                       border_y: r_pend.border_y,
                                       point_index: r_pend.point_index,
                                       end_of_run: 1'b1, status: r_pend.status};
                        end
                        r_pend_valid <= 1'b0;
                        r_cnt        <= '0;
                        r_min_x      <= '1;
                        r_min_y      <= '1;
                        r_max_x      <= '0;
                        r_max_y      <= '0;
                        r_ovf        <= 1'b0;
                        r_clr        <= '0;
                        r_state      <= S_CLEAR;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

[hw/rtl/cbpe_checker.sv]
`timescale 1ns / 1ps

module cbpe_checker
    import cbpe_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |->
            o_out_data.end_of_run && (o_out_data.border_x == '0) &&
            (o_out_data.border_y == '0) && (o_out_data.point_index == '0))
        else $error("error result with nonzero payload or open run");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK) ||
            (o_out_data.status == ST_OVERFLOW) || (o_out_data.status == ST_EXTENT))
        else $error("undefined status code");

    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last |=> !o_in_ready)
        else $error("input taken right after final point");

endmodule

bind cluster_border_pixel_extract cbpe_checker u_cbpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import cbpe_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int PHASE_ITEMS    = 92;
    localparam int HOLD_CYCLES    = 600;
    localparam int TAIL_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;
    localparam int COORD_TOP      = (1 << COORD_BITS) - 1;

    class border_scoreboard;
        logic [COORD_BITS-1:0] pt_x[MAX_POINTS];
        logic [COORD_BITS-1:0] pt_y[MAX_POINTS];
        int unsigned n_pts;
        int unsigned lo_x, lo_y, hi_x, hi_y;
        bit          too_many;
        t_out        pending_q[$];
        int unsigned n_mismatch, n_clusters, n_border, n_overflow, n_extent;

        function new();
            n_mismatch = 0;
            n_clusters = 0;
            n_border   = 0;
            n_overflow = 0;
            n_extent   = 0;
            restart();
        endfunction

        function void restart();
            n_pts    = 0;
            lo_x     = COORD_TOP;
            lo_y     = COORD_TOP;
            hi_x     = 0;
            hi_y     = 0;
            too_many = 1'b0;
        endfunction

        function void note_point(t_in item);
            bit   occ[WINDOW][WINDOW];
            t_out res;
            int   k, dr, dc, cx, cy, n_found;
            bit   on_rim;

            if (n_pts < MAX_POINTS) begin
                pt_x[n_pts] = item.x;
                pt_y[n_pts] = item.y;
                n_pts++;
                if (item.x < lo_x) lo_x = 32'(item.x);
                if (item.x > hi_x) hi_x = 32'(item.x);
                if (item.y < lo_y) lo_y = 32'(item.y);
                if (item.y > hi_y) hi_y = 32'(item.y);
            end else begin
                too_many = 1'b1;
            end
            if (!item.last) return;

            n_clusters++;
            res = '0;
            res.end_of_run = 1'b1;
            if (too_many) begin
                res.status = ST_OVERFLOW;
                pending_q = {pending_q, res};
                n_overflow++;
            end else if (hi_x - lo_x + MARGIN_SPAN > WINDOW ||
                         hi_y - lo_y + MARGIN_SPAN > WINDOW) begin
                res.status = ST_EXTENT;
                pending_q = {pending_q, res};
                n_extent++;
            end else begin
                foreach (occ[r, c]) occ[r][c] = 1'b0;
                for (k = 0; k < n_pts; k++)
                    occ[pt_y[k] - lo_y + 1][pt_x[k] - lo_x + 1] = 1'b1;
                n_found = 0;
                for (k = 0; k < n_pts; k++) begin
                    cx = pt_x[k] - lo_x + 1;
                    cy = pt_y[k] - lo_y + 1;
                    on_rim = 1'b0;
                    for (dc = -1; dc <= 1; dc++)
                        for (dr = -1; dr <= 1; dr++)
                            if ((dc != 0 || dr != 0) && !occ[cy + dr][cx + dc])
                                on_rim = 1'b1;
                    if (on_rim) begin
                        res             = '0;
                        res.border_x    = pt_x[k];
                        res.border_y    = pt_y[k];
                        res.point_index = PIDX_W'(k);
                        res.status      = ST_OK;
                        pending_q = {pending_q, res};
                        n_found++;
                    end
                end
                if (n_found > 0) begin
                    res = pending_q.pop_back();
                    res.end_of_run = 1'b1;
                    pending_q = {pending_q, res};
                end
                n_border += n_found;
            end
            restart();
        endfunction

        function void check_result(t_out got);
            t_out want;

            if (pending_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("%0t: unexpected result x=%0d y=%0d idx=%0d eor=%0b st=%0d",
                             $time, got.border_x, got.border_y, got.point_index,
                             got.end_of_run, got.status);
                return;
            end
            want = pending_q.pop_front();
            if (got.border_x !== want.border_x || got.border_y !== want.border_y ||
                got.point_index !== want.point_index ||
                got.end_of_run !== want.end_of_run || got.status !== want.status) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS) begin
                    $write("%0t: mismatch exp x=%0d y=%0d idx=%0d eor=%0b st=%0d",
                           $time, want.border_x, want.border_y, want.point_index,
                           want.end_of_run, want.status);
                    $display(" got x=%0d y=%0d idx=%0d eor=%0b st=%0d",
                             got.border_x, got.border_y, got.point_index,
                             got.end_of_run, got.status);
                end
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in         i_in_data   = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out        o_out_data;

    border_scoreboard sb = new();

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned n_sent    = 0;

    wire in_fire  = i_rst_n && i_in_valid && o_in_ready;
    wire out_fire = i_rst_n && o_out_valid && i_out_ready;

    cluster_border_pixel_extract u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (in_fire) sb.note_point(i_in_data);
        if (out_fire) sb.check_result(o_out_data);
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen   <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (in_fire || out_fire) quiet = 0;
            else quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_point(input int px, input int py, input logic last);
        t_in item;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        item.x     = COORD_BITS'(px);
        item.y     = COORD_BITS'(py);
        item.last  = last;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_cluster();
        int n, sel, span_x, span_y, bx, by, i;
        sel = $urandom_range(0, 19);
        if (sel == 0) n = MAX_POINTS;
        else if (sel == 1) n = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 3);
        else if (sel < 6) n = $urandom_range(1, 3);
        else n = $urandom_range(4, 24);
        sel = $urandom_range(0, 9);
        if (sel == 0 || (n > MAX_POINTS && sel < 5)) begin
            span_x = $urandom_range(58, 90);
            span_y = $urandom_range(0, 90);
        end else if (sel < 3) begin
            span_x = $urandom_range(0, 2);
            span_y = $urandom_range(0, 2);
        end else begin
            span_x = $urandom_range(2, 12);
            span_y = $urandom_range(2, 12);
        end
        if ($urandom_range(0, 1)) begin
            i = span_x;
            span_x = span_y;
            span_y = i;
        end
        case ($urandom_range(0, 5))
            0: bx = 0;
            1: bx = COORD_TOP - span_x;
            default: bx = $urandom_range(0, COORD_TOP - span_x);
        endcase
        case ($urandom_range(0, 5))
            0: by = 0;
            1: by = COORD_TOP - span_y;
            default: by = $urandom_range(0, COORD_TOP - span_y);
        endcase
        for (i = 0; i < n; i++)
            send_point(bx + $urandom_range(0, span_x), by + $urandom_range(0, span_y),
                       i == n - 1);
    endtask

    initial begin : stimulus
        int r, c, p, phase_start;
        int unsigned idle_tbl[4];
        int unsigned stall_tbl[4];

        idle_tbl  = '{0, 87, 0, 32};
        stall_tbl = '{0, 0, 87, 32};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner points, duplicates, a solid block with one interior point
        send_point(0, 0, 1'b1);
        send_point(COORD_TOP, COORD_TOP, 1'b1);
        send_point(5, 7, 1'b0);
        send_point(5, 7, 1'b1);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                send_point(COORD_TOP - 2 + c, r, r == 2 && c == 2);
        // box too wide, too tall, and exactly at the window limit
        send_point(0, 100, 1'b0);
        send_point(WINDOW - 2, 100, 1'b1);
        send_point(500, 0, 1'b0);
        send_point(500, WINDOW - 2, 1'b1);
        send_point(10, COORD_TOP - WINDOW + MARGIN_SPAN, 1'b0);
        send_point(10 + WINDOW - MARGIN_SPAN, COORD_TOP, 1'b1);
        wait_drain();

        for (p = 0; p < 4; p++) begin
            idle_pct  = idle_tbl[p];
            stall_pct <= stall_tbl[p];
            if (p == 0) hold_reqs <= hold_reqs + 1;
            phase_start = n_sent;
            while (n_sent - phase_start < PHASE_ITEMS)
                send_random_cluster();
            wait_drain();
        end

        stall_pct <= 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d points in %0d clusters; checked %0d border points,",
                 n_sent, sb.n_clusters, sb.n_border);
        $display("%0d overflow and %0d oversized-box errors, across four handshake phases",
                 sb.n_overflow, sb.n_extent);
        if (sb.pending_q.size() != 0)
            $display("%0d expected results never arrived", sb.pending_q.size());
        if (sb.n_mismatch == 0 && sb.pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.n_mismatch);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[cluster_border_pixel_extract.f]
hw/rtl/cbpe_pkg.sv
hw/rtl/cbpe_ram.sv
hw/rtl/cluster_border_pixel_extract.sv
hw/rtl/cbpe_checker.sv
bench/tb.sv
